[design/ufs_pkg.sv]
package ufs_pkg;

  typedef enum logic [2:0] {
    PH_SCHEME = 3'd0,
    PH_HOST   = 3'd1,
    PH_PORT   = 3'd2,
    PH_PATH   = 3'd3,
    PH_QUERY  = 3'd4
  } phase_t;

  localparam logic [2:0] KIND_SCHEME = 3'd0;
  localparam logic [2:0] KIND_HOST   = 3'd1;
  localparam logic [2:0] KIND_PATH   = 3'd2;
  localparam logic [2:0] KIND_KEY    = 3'd3;
  localparam logic [2:0] KIND_VALUE  = 3'd4;

  localparam logic [1:0] MARK_DATA   = 2'd0;
  localparam logic [1:0] MARK_NEWPAR = 2'd1;
  localparam logic [1:0] MARK_SEP    = 2'd2;
  localparam logic [1:0] MARK_END    = 2'd3;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_NOSCHEME = 2'd1;
  localparam logic [1:0] ERR_PORTOVF  = 2'd2;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  localparam logic [15:0] DEFAULT_PORT_RST = 16'd80;
  localparam logic [15:0] PORT_MAX         = 16'hFFFF;

  // results one item can cause
  localparam int MAX_RES = 4;

  typedef struct packed {
    logic [7:0]  data;
    logic [2:0]  kind;
    logic [1:0]  mark;
    logic [15:0] port;
    logic [1:0]  err;
  } res_t;

  function automatic res_t mk_res(logic [7:0] data, logic [2:0] kind, logic [1:0] mark,
                                  logic [15:0] port, logic [1:0] err);
    res_t r;
    r.data = data;
    r.kind = kind;
    r.mark = mark;
    r.port = port;
    r.err  = err;
    return r;
  endfunction

endpackage

[design/url_field_splitter.sv]
// Channel | Direction | Handshake              | Payload
// in_     | slave     | in_tvalid / in_tready  | tdata[7:0] byte, tlast end of URL
// out_    | master    | out_tvalid / out_tready| tdata byte/port/error, tuser kind/mark,
//         |           |                        | tlast final result of the item
// cfg_    | slave     | cfg_valid / cfg_ready  | cfg_data default port
//
// An item is decoded in the cycle it is accepted; its zero to four results are
// loaded into a small result buffer that drains one result per cycle while
// out_tready is high. The next item is taken in the cycle the last result of
// the current one leaves, or at once when the item caused no result.
// Reset (rst_n low, synchronous) returns the parser to the scheme phase,
// empties the buffer and sets the default port to 80.
// A stalled output holds its result and blocks input until the last result
// of the current item is taken.
module url_field_splitter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] out_byte, [23:8] port, [25:24] error, zero above
  output logic [7:0]  out_tuser,  // [2:0] field_kind, [4:3] mark, zero above
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int CntW = $clog2(ufs_pkg::MAX_RES + 1);
  localparam int IdxW = $clog2(ufs_pkg::MAX_RES);

  ufs_pkg::phase_t phase_r, phase_upd, phase_nxt;
  logic [1:0]  pend_r, pend_upd, pend_nxt;
  logic [15:0] port_val_r, port_val_upd, port_val_nxt;
  logic        port_seen_r, port_seen_upd, port_seen_nxt;
  logic        port_done_r, port_done_upd, port_done_nxt;
  logic        value_open_r, value_open_upd, value_open_nxt;
  logic        port_over_r, port_over_upd, port_over_nxt;
  logic [15:0] dflt_port_r;

  ufs_pkg::res_t buf_r [ufs_pkg::MAX_RES];
  logic [CntW-1:0] cnt_r;

  ufs_pkg::res_t lst [ufs_pkg::MAX_RES];
  logic [CntW-1:0] n_res;

  logic [7:0]  c;
  logic        in_acc, out_acc;
  logic        is_digit;
  logic [19:0] port_mul;
  logic        held;
  logic        vo_eff;

  assign c        = in_tdata;
  assign in_acc   = in_tvalid && in_tready;
  assign out_acc  = out_tvalid && out_tready;
  assign is_digit = (c >= ufs_pkg::CH_0) && (c <= ufs_pkg::CH_9);
  assign port_mul = {1'b0, port_val_r, 3'b000} + {3'b000, port_val_r, 1'b0}
                  + {16'd0, c[3:0] - ufs_pkg::CH_0[3:0]};
  assign held     = (pend_r != 2'd0);
  assign vo_eff   = held ? 1'b0 : value_open_r;

  // next state for one byte, then the end-of-URL clear
  always_comb begin
    phase_upd      = phase_r;
    pend_upd       = pend_r;
    port_val_upd   = port_val_r;
    port_seen_upd  = port_seen_r;
    port_done_upd  = port_done_r;
    value_open_upd = value_open_r;
    port_over_upd  = port_over_r;
    unique case (phase_r)
      ufs_pkg::PH_SCHEME: begin
        if (pend_r == 2'd1 && c == ufs_pkg::CH_SLASH) begin
          pend_upd = 2'd2;
        end else if (pend_r == 2'd2 && c == ufs_pkg::CH_SLASH) begin
          phase_upd = ufs_pkg::PH_HOST;
          pend_upd  = 2'd0;
        end else begin
          pend_upd = (c == ufs_pkg::CH_COLON) ? 2'd1 : 2'd0;
        end
      end
      ufs_pkg::PH_HOST: begin
        if (c == ufs_pkg::CH_SLASH) begin
          phase_upd = ufs_pkg::PH_PATH;
        end else if (c == ufs_pkg::CH_COLON) begin
          port_seen_upd = 1'b1;
          phase_upd     = ufs_pkg::PH_PORT;
        end
      end
      ufs_pkg::PH_PORT: begin
        if (c == ufs_pkg::CH_SLASH) begin
          phase_upd = ufs_pkg::PH_PATH;
        end else if (!port_done_r && is_digit) begin
          if (port_mul > {4'd0, ufs_pkg::PORT_MAX}) begin
            port_val_upd  = ufs_pkg::PORT_MAX;
            port_over_upd = 1'b1;
          end else begin
            port_val_upd = port_mul[15:0];
          end
        end else begin
          port_done_upd = 1'b1;
        end
      end
      ufs_pkg::PH_PATH: begin
        if (c == ufs_pkg::CH_QMARK) begin
          phase_upd      = ufs_pkg::PH_QUERY;
          value_open_upd = 1'b0;
          pend_upd       = 2'd0;
        end
      end
      ufs_pkg::PH_QUERY: begin
        value_open_upd = vo_eff;
        pend_upd       = (c == ufs_pkg::CH_AMP) ? 2'd1 : 2'd0;
        if (c == ufs_pkg::CH_EQ && !vo_eff) begin
          value_open_upd = 1'b1;
        end
      end
      default: begin
        phase_upd = ufs_pkg::PH_SCHEME;
      end
    endcase

    phase_nxt      = phase_upd;
    pend_nxt       = pend_upd;
    port_val_nxt   = port_val_upd;
    port_seen_nxt  = port_seen_upd;
    port_done_nxt  = port_done_upd;
    value_open_nxt = value_open_upd;
    port_over_nxt  = port_over_upd;
    if (in_tlast) begin
      phase_nxt      = ufs_pkg::PH_SCHEME;
      pend_nxt       = 2'd0;
      port_val_nxt   = 16'd0;
      port_seen_nxt  = 1'b0;
      port_done_nxt  = 1'b0;
      value_open_nxt = 1'b0;
      port_over_nxt  = 1'b0;
    end
  end

  // results caused by one byte, in order
  always_comb begin
    for (int i = 0; i < ufs_pkg::MAX_RES; i++) begin
      lst[i] = ufs_pkg::mk_res(8'd0, ufs_pkg::KIND_SCHEME, ufs_pkg::MARK_DATA, 16'd0,
                               ufs_pkg::ERR_OK);
    end
    n_res = '0;
    unique case (phase_r)
      ufs_pkg::PH_SCHEME: begin
        if (pend_r != 2'd0 && c != ufs_pkg::CH_SLASH) begin
          // flush the broken separator
          lst[n_res[IdxW-1:0]] = ufs_pkg::mk_res(ufs_pkg::CH_COLON, ufs_pkg::KIND_SCHEME,
                                                 ufs_pkg::MARK_DATA, 16'd0, ufs_pkg::ERR_OK);
          n_res = n_res + 1'b1;
          if (pend_r == 2'd2) begin
            lst[n_res[IdxW-1:0]] = ufs_pkg::mk_res(ufs_pkg::CH_SLASH, ufs_pkg::KIND_SCHEME,
                                                   ufs_pkg::MARK_DATA, 16'd0, ufs_pkg::ERR_OK);
            n_res = n_res + 1'b1;
          end
        end
        if ((pend_r == 2'd0 || c != ufs_pkg::CH_SLASH) && c != ufs_pkg::CH_COLON) begin
          lst[n_res[IdxW-1:0]] = ufs_pkg::mk_res(c, ufs_pkg::KIND_SCHEME, ufs_pkg::MARK_DATA,
                                                 16'd0, ufs_pkg::ERR_OK);
          n_res = n_res + 1'b1;
        end
      end
      ufs_pkg::PH_HOST: begin
        if (c == ufs_pkg::CH_SLASH) begin
          lst[n_res[IdxW-1:0]] = ufs_pkg::mk_res(c, ufs_pkg::KIND_PATH, ufs_pkg::MARK_DATA,
                                                 16'd0, ufs_pkg::ERR_OK);
          n_res = n_res + 1'b1;
        end else if (c != ufs_pkg::CH_COLON) begin
          lst[n_res[IdxW-1:0]] = ufs_pkg::mk_res(c, ufs_pkg::KIND_HOST, ufs_pkg::MARK_DATA,
                                                 16'd0, ufs_pkg::ERR_OK);
          n_res = n_res + 1'b1;
        end
      end
      ufs_pkg::PH_PORT: begin
        if (c == ufs_pkg::CH_SLASH) begin
          lst[n_res[IdxW-1:0]] = ufs_pkg::mk_res(c, ufs_pkg::KIND_PATH, ufs_pkg::MARK_DATA,
                                                 16'd0, ufs_pkg::ERR_OK);
          n_res = n_res + 1'b1;
        end
      end
      ufs_pkg::PH_PATH: begin
        if (c == ufs_pkg::CH_QMARK) begin
          lst[n_res[IdxW-1:0]] = ufs_pkg::mk_res(8'd0, ufs_pkg::KIND_KEY, ufs_pkg::MARK_NEWPAR,
                                                 16'd0, ufs_pkg::ERR_OK);
        end else begin
          lst[n_res[IdxW-1:0]] = ufs_pkg::mk_res(c, ufs_pkg::KIND_PATH, ufs_pkg::MARK_DATA,
                                                 16'd0, ufs_pkg::ERR_OK);
        end
        n_res = n_res + 1'b1;
      end
      ufs_pkg::PH_QUERY: begin
        if (held) begin
          // release the held '&' now that another byte follows
          lst[n_res[IdxW-1:0]] = ufs_pkg::mk_res(8'd0, ufs_pkg::KIND_KEY, ufs_pkg::MARK_NEWPAR,
                                                 16'd0, ufs_pkg::ERR_OK);
          n_res = n_res + 1'b1;
        end
        if (c == ufs_pkg::CH_EQ && !vo_eff) begin
          lst[n_res[IdxW-1:0]] = ufs_pkg::mk_res(8'd0, ufs_pkg::KIND_VALUE, ufs_pkg::MARK_SEP,
                                                 16'd0, ufs_pkg::ERR_OK);
          n_res = n_res + 1'b1;
        end else if (c != ufs_pkg::CH_AMP) begin
          lst[n_res[IdxW-1:0]] = ufs_pkg::mk_res(c, vo_eff ? ufs_pkg::KIND_VALUE
                                                           : ufs_pkg::KIND_KEY,
                                                 ufs_pkg::MARK_DATA, 16'd0, ufs_pkg::ERR_OK);
          n_res = n_res + 1'b1;
        end
      end
      default: begin
        n_res = '0;
      end
    endcase

    if (in_tlast) begin
      if (phase_upd == ufs_pkg::PH_SCHEME) begin
        if (pend_upd != 2'd0) begin
          lst[n_res[IdxW-1:0]] = ufs_pkg::mk_res(ufs_pkg::CH_COLON, ufs_pkg::KIND_SCHEME,
                                                 ufs_pkg::MARK_DATA, 16'd0, ufs_pkg::ERR_OK);
          n_res = n_res + 1'b1;
        end
        if (pend_upd == 2'd2) begin
          lst[n_res[IdxW-1:0]] = ufs_pkg::mk_res(ufs_pkg::CH_SLASH, ufs_pkg::KIND_SCHEME,
                                                 ufs_pkg::MARK_DATA, 16'd0, ufs_pkg::ERR_OK);
          n_res = n_res + 1'b1;
        end
      end
      lst[n_res[IdxW-1:0]] = ufs_pkg::mk_res(8'd0, ufs_pkg::KIND_SCHEME, ufs_pkg::MARK_END,
          port_seen_upd ? port_val_upd : dflt_port_r,
          (phase_upd == ufs_pkg::PH_SCHEME) ? ufs_pkg::ERR_NOSCHEME :
          (port_over_upd ? ufs_pkg::ERR_PORTOVF : ufs_pkg::ERR_OK));
      n_res = n_res + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= ufs_pkg::PH_SCHEME;
      pend_r       <= 2'd0;
      port_val_r   <= 16'd0;
      port_seen_r  <= 1'b0;
      port_done_r  <= 1'b0;
      value_open_r <= 1'b0;
      port_over_r  <= 1'b0;
      dflt_port_r  <= ufs_pkg::DEFAULT_PORT_RST;
      cnt_r        <= '0;
    end else begin
      if (cfg_valid) begin
        dflt_port_r <= cfg_data;
      end
      if (in_acc) begin
        phase_r      <= phase_nxt;
        pend_r       <= pend_nxt;
        port_val_r   <= port_val_nxt;
        port_seen_r  <= port_seen_nxt;
        port_done_r  <= port_done_nxt;
        value_open_r <= value_open_nxt;
        port_over_r  <= port_over_nxt;
        cnt_r        <= n_res;
      end else if (out_acc) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // result buffer: load on accept, else advance on take
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < ufs_pkg::MAX_RES; i++) begin
        buf_r[i] <= lst[i];
      end
    end else if (out_acc) begin
      for (int i = 0; i < ufs_pkg::MAX_RES - 1; i++) begin
        buf_r[i] <= buf_r[i+1];
      end
    end
  end

  assign in_tready  = (cnt_r == '0) || ((cnt_r == CntW'(1)) && out_tready);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = (cnt_r != '0);
  assign out_tlast  = (cnt_r == CntW'(1));
  assign out_tdata  = {6'd0, buf_r[0].err, buf_r[0].port, buf_r[0].data};
  assign out_tuser  = {3'd0, buf_r[0].mark, buf_r[0].kind};

endmodule

[design/ufs_checker.sv]
module ufs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [7:0]  out_tuser,
  input logic        out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("stalled result changed");

  // end mark always closes the results of its item
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[4:3] == ufs_pkg::MARK_END |-> out_tlast)
    else $error("end mark without tlast");

  // port and error are only carried on the end mark
  a_port_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[4:3] != ufs_pkg::MARK_END |-> out_tdata[25:8] == 18'd0)
    else $error("port or error outside end mark");

  // a new-parameter mark is tagged as query key
  a_newpar_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[4:3] == ufs_pkg::MARK_NEWPAR |-> out_tuser[2:0] == ufs_pkg::KIND_KEY)
    else $error("new-parameter mark with wrong kind");

  // input only blocks while results are waiting
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no pending result");

endmodule

bind url_field_splitter ufs_checker u_ufs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
